/* hdl/b64e_pkg.sv */
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      final_idx;
      logic            last;
   } job_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v inside {[6'd0:6'd25]}) begin
         c = 8'h41 + w;
      end else if (v inside {[6'd26:6'd51]}) begin
         c = 8'h61 + w - 8'd26;
      end else if (v inside {[6'd52:6'd61]}) begin
         c = 8'h30 + w - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

/* hdl/base64_stream_encoder.sv */
// Standard base64 encoder for a byte stream.
// Requests arrive on the req_ channel, one message byte each, with
// req_last_byte high on the final byte of a message. Characters leave on the
// rsp_ channel, one per cycle while the receiver is ready, with rsp_last_char
// high on the final character of the message, after any '=' padding.
// The front stage takes a byte in the cycle it is offered, as long as the job
// queue has room, and turns it into one to four characters. The back stage
// sends one character per cycle while rsp_ready is high, through an output register.
// An accepted request is written into the job queue and then loaded into the output register.
// Throughput is set by the single output port: one character per cycle while
// the receiver is ready, so a byte yields one or two characters, about 1.33 on
// average, and up to four on the last byte of a message.
// Reset clears the group phase, the queue count and the output valid flag.
// When the receiver stalls, the output holds its character, the queue
// fills, and req_ready drops once QUEUE_DEPTH jobs are waiting.
module base64_stream_encoder
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_char,
   output logic       rsp_last_char
);

   logic    q_full, q_empty, q_push, q_pop;
   job_type push_job, head_job;

   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_job         (head_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_char (rsp_code_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* hdl/b64e_front.sv */
module b64e_front
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       q_full,
   output logic       q_push,
   output job_type    q_job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      q_job       = '0;
      q_job.last  = req_last_byte;
      phase_in    = phase_ff;
      carry_in    = carry_ff;
      case (phase_ff)
         PHASE_SECOND: begin
            q_job.chars[0] = enc_char({carry_ff[1:0], req_data_byte[7:4]});
            if (req_last_byte) begin
               q_job.chars[1]  = enc_char({req_data_byte[3:0], 2'b00});
               q_job.chars[2]  = PAD_CHAR;
               q_job.final_idx = 2'd2;
            end
            phase_in = PHASE_THIRD;
            carry_in = req_data_byte[3:0];
         end
         PHASE_THIRD: begin
            q_job.chars[0]  = enc_char({carry_ff, req_data_byte[7:6]});
            q_job.chars[1]  = enc_char(req_data_byte[5:0]);
            q_job.final_idx = 2'd1;
            phase_in        = PHASE_FIRST;
            carry_in        = 4'd0;
         end
         default: begin
            q_job.chars[0] = enc_char(req_data_byte[7:2]);
            if (req_last_byte) begin
               q_job.chars[1]  = enc_char({req_data_byte[1:0], 4'b0000});
               q_job.chars[2]  = PAD_CHAR;
               q_job.chars[3]  = PAD_CHAR;
               q_job.final_idx = 2'd3;
            end
            phase_in = PHASE_SECOND;
            carry_in = {2'b00, req_data_byte[1:0]};
         end
      endcase
      if (req_last_byte) begin
         phase_in = PHASE_FIRST;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

/* hdl/b64e_queue.sv */
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type head_job,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

endmodule

/* hdl/b64e_back.sv */
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_char,
   output logic       rsp_last_char
);

   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic [1:0] idx_ff;
   logic       load;
   logic       at_end;

   assign load   = !q_empty && (!valid_ff || rsp_ready);
   assign at_end = (idx_ff == q_job.final_idx);
   assign q_pop  = load && at_end;

   assign rsp_valid     = valid_ff;
   assign rsp_code_char = char_ff;
   assign rsp_last_char = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= q_job.chars[idx_ff];
         last_ff <= q_job.last && at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= at_end ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* sim/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import b64e_pkg::*;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } b64_char_type;

   localparam int HOLD_CYCLES  = 200;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 20;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_ready     = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [7:0] rsp_code_char;
   logic       rsp_last_char;

   string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   b64_char_type expected_chars[$];
   b64_char_type next_char;
   logic [1:0] enc_phase     = PHASE_FIRST;
   logic [3:0] enc_carry     = 4'h0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         fault_count   = 0;
   int         quiet_cycles  = 0;
   int         hold_left     = 0;
   logic       hold_trigger  = 1'b0;
   logic       hold_seen     = 1'b0;

   base64_stream_encoder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_char (rsp_code_char),
      .rsp_last_char (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] base64_symbol(input logic [5:0] v);
      return alphabet[int'(v)];
   endfunction

   // Advances the encoder state by one byte and queues the characters it yields.
   task automatic encode_byte(input logic [7:0] b, input logic l);
      logic [7:0]   chars [4];
      int           n;
      b64_char_type item;
      n = 0;
      case (enc_phase)
         PHASE_SECOND: begin
            chars[0] = base64_symbol({enc_carry[1:0], b[7:4]});
            n = 1;
            if (l) begin
               chars[1] = base64_symbol({b[3:0], 2'b00});
               chars[2] = PAD_CHAR;
               n = 3;
            end else begin
               enc_carry = b[3:0];
               enc_phase = PHASE_THIRD;
            end
         end
         PHASE_THIRD: begin
            chars[0] = base64_symbol({enc_carry, b[7:6]});
            chars[1] = base64_symbol(b[5:0]);
            n = 2;
            enc_carry = 4'h0;
            enc_phase = PHASE_FIRST;
         end
         default: begin
            chars[0] = base64_symbol(b[7:2]);
            n = 1;
            if (l) begin
               chars[1] = base64_symbol({b[1:0], 4'h0});
               chars[2] = PAD_CHAR;
               chars[3] = PAD_CHAR;
               n = 4;
            end else begin
               enc_carry = {2'b00, b[1:0]};
               enc_phase = PHASE_SECOND;
            end
         end
      endcase
      if (l) begin
         enc_phase = PHASE_FIRST;
         enc_carry = 4'h0;
      end
      for (int i = 0; i < n; i++) begin
         item.code = chars[i];
         item.last = l && (i == n - 1);
         expected_chars.push_back(item);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      encode_byte(b, l);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // Each entry is {last, data}; messages end in every group phase and hit '+' and '/'.
   task automatic test_boundary_bytes();
      logic [8:0] corner [22] = '{
         9'h100, 9'h1FF, 9'h0FF, 9'h100, 9'h000, 9'h0FF, 9'h180, 9'h0FF,
         9'h0FF, 9'h1FF, 9'h0FB, 9'h0EF, 9'h1BE, 9'h055, 9'h0AA, 9'h055,
         9'h1AA, 9'h0AA, 9'h055, 9'h0AA, 9'h055, 9'h1AA};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (corner[i]) begin
         send_byte(corner[i][7:0], corner[i][8]);
      end
   endtask

   task automatic test_random_messages(input int count);
      int sent;
      int len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
         send_message(len);
         sent += len;
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_trigger <= ~hold_trigger;
      send_message(5);
      send_message(7);
   endtask

   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            if (fault_count < 10) begin
               $display("unexpected character: code %h last %b", rsp_code_char, rsp_last_char);
            end
            fault_count++;
         end else begin
            next_char = expected_chars.pop_front();
            if (rsp_code_char !== next_char.code || rsp_last_char !== next_char.last) begin
               if (fault_count < 10) begin
                  $display("mismatch: expected code %h last %b, got code %h last %b",
                           next_char.code, next_char.last, rsp_code_char, rsp_last_char);
               end
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_boundary_bytes();
      send_idle_pct = 32;
      recv_idle_pct = 85;
      test_random_messages(22);
      send_idle_pct = 85;
      recv_idle_pct = 32;
      test_random_messages(22);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_messages(20);
      test_output_stall();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && expected_chars.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
sim/testbench.sv
